@@ hdl/lfr_pkg.sv @@
// lfr_pkg: shared types and constants of the led fade ramp generator
// depends on nothing; used by every other file of the block
`timescale 1ns / 1ps

package lfr_pkg;

	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned DELAY_W    = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [DELAY_W-1:0] delay_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_SIZE   = 3'd0,
		REG_STEP_DELAY  = 3'd1,
		REG_START_LEVEL = 3'd2,
		REG_END_LEVEL   = 3'd3,
		REG_REPEATABLE  = 3'd4,
		REG_REVERSIBLE  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		level_t step_size;
		delay_t step_delay;
		level_t start_level;
		level_t end_level;
		logic   repeatable;
		logic   reversible;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		step_size:   8'd1,
		step_delay:  16'd10,
		start_level: 8'd0,
		end_level:   8'd255,
		repeatable:  1'b0,
		reversible:  1'b0
	};

	typedef struct packed {
		level_t brightness;
		logic   going_down;
		logic   reversed_once;
		logic   halted;
		delay_t wait_count;
	} ramp_state_t;

	typedef struct packed {
		level_t level;
		logic   stopped;
		logic   descending;
	} result_t;

endpackage

@@ hdl/lfr_if.sv @@
// lfr channel interfaces: tick input, result output, register write port
// depends on lfr_pkg for field widths
`timescale 1ns / 1ps

interface lfr_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface lfr_result_if;
	logic                 valid;
	logic                 ready;
	lfr_pkg::level_t      level;
	logic                 stopped;
	logic                 descending;

	modport source (output valid, output level, output stopped, output descending,
		input ready);
	modport sink   (input valid, input level, input stopped, input descending,
		output ready);
endinterface

interface lfr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [lfr_pkg::CFG_IDX_W-1:0]      index;
	logic [lfr_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/led_fade_ramp_generator_top.sv @@
// led fade ramp generator: tick in, one result beat out per tick
// an accepted tick waits in the input stage until the result stage takes it
// throughput: one tick per cycle while the result output is not stalled
// empty input stage always takes a tick; a full one only when s2 can advance
// reset (arst_n low): valid bits clear, cfg resets, state holds start level
`timescale 1ns / 1ps

module led_fade_ramp_generator_top (
	input  logic          clk,
	input  logic          arst_n,
	lfr_tick_if.sink      tick,
	lfr_result_if.source  result,
	lfr_cfg_if.sink       cfg
);
	import lfr_pkg::*;

	cfg_t    regs;
	result_t res_next;

	logic    valid_s1;
	logic    restart_s1;
	logic    valid_s2;
	result_t res_s2;

	logic    adv_s2;
	logic    fire_s1;
	logic    tick_acc;

	assign adv_s2     = !valid_s2 || result.ready;
	assign fire_s1    = valid_s1 && adv_s2;
	assign tick.ready = !valid_s1 || adv_s2;
	assign tick_acc   = tick.valid && tick.ready;

	lfr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lfr_ramp_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.step_en  (fire_s1),
		.restart  (restart_s1),
		.res_next (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (tick_acc) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			restart_s1 <= tick.restart;
		end
		if (fire_s1) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid      = valid_s2;
	assign result.level      = res_s2.level;
	assign result.stopped    = res_s2.stopped;
	assign result.descending = res_s2.descending;

`ifndef SYNTH
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(restart_s1))
		else $error("input stage dropped a beat");
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready |=> valid_s2 && $stable(res_s2))
		else $error("result stage dropped a beat");
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> tick.ready)
		else $error("empty input stage refused a tick");
`endif

endmodule

@@ hdl/lfr_cfg_regs.sv @@
// lfr_cfg_regs: configuration register file, one write beat per cycle
// depends on lfr_pkg and lfr_cfg_if
`timescale 1ns / 1ps

module lfr_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	lfr_cfg_if.sink       cfg,
	output lfr_pkg::cfg_t regs
);
	import lfr_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_STEP_SIZE:   regs_q.step_size   <= cfg.data[LEVEL_W-1:0];
				REG_STEP_DELAY:  regs_q.step_delay  <= cfg.data[DELAY_W-1:0];
				REG_START_LEVEL: regs_q.start_level <= cfg.data[LEVEL_W-1:0];
				REG_END_LEVEL:   regs_q.end_level   <= cfg.data[LEVEL_W-1:0];
				REG_REPEATABLE:  regs_q.repeatable  <= cfg.data[0];
				REG_REVERSIBLE:  regs_q.reversible  <= cfg.data[0];
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_ready_high: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.ready)
		else $error("cfg port not ready");
	a_no_write_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.valid |=> $stable(regs_q))
		else $error("register changed without a write beat");
	a_reversible_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.index == REG_REVERSIBLE |=> regs_q.reversible == $past(cfg.data[0]))
		else $error("reversible flag write lost");
`endif

endmodule

@@ hdl/lfr_ramp_state.sv @@
// lfr_ramp_state: ramp state registers and the per-tick update logic
// depends on lfr_pkg
`timescale 1ns / 1ps

module lfr_ramp_state (
	input  logic             clk,
	input  logic             arst_n,
	input  lfr_pkg::cfg_t    regs,
	input  logic             step_en,
	input  logic             restart,
	output lfr_pkg::result_t res_next
);
	import lfr_pkg::*;

	localparam ramp_state_t STATE_RESET = '{
		brightness:    CFG_RESET.start_level,
		going_down:    !(CFG_RESET.start_level < CFG_RESET.end_level),
		reversed_once: 1'b0,
		halted:        1'b0,
		wait_count:    '0
	};

	ramp_state_t st_q;
	ramp_state_t st_d;

	always_comb begin
		ramp_state_t s;
		level_t      hi;
		level_t      lo;
		logic        at_bound;
		logic [LEVEL_W:0] sum;
		s        = st_q;
		hi       = (regs.start_level < regs.end_level) ? regs.end_level : regs.start_level;
		lo       = (regs.start_level < regs.end_level) ? regs.start_level : regs.end_level;
		if (restart) begin
			s.brightness    = regs.start_level;
			s.reversed_once = 1'b0;
			s.halted        = 1'b0;
			s.going_down    = !(regs.start_level < regs.end_level);
			s.wait_count    = '0;
		end
		at_bound = (!s.going_down && s.brightness >= hi) ||
			(s.going_down && s.brightness <= lo);
		sum      = {1'b0, s.brightness} + {1'b0, regs.step_size};
		if (s.wait_count != '0) begin
			s.wait_count = s.wait_count - 1'b1;
		end else if (regs.start_level != regs.end_level) begin
			if (at_bound) begin
				if (regs.repeatable) begin
					if (regs.reversible) begin
						s.going_down    = !s.going_down;
						s.reversed_once = 1'b1;
					end else begin
						s.brightness    = regs.start_level;
						s.reversed_once = 1'b0;
						s.halted        = 1'b0;
						s.going_down    = !(regs.start_level < regs.end_level);
					end
				end else if (regs.reversible) begin
					if (s.reversed_once) begin
						s.halted = 1'b1;
					end else begin
						s.going_down    = !s.going_down;
						s.reversed_once = 1'b1;
					end
				end else begin
					s.halted = 1'b1;
				end
				// restart branch reloads brightness, so recompute the sum
				sum = {1'b0, s.brightness} + {1'b0, regs.step_size};
			end
			if (!s.halted) begin
				if (!s.going_down) begin
					s.brightness = sum[LEVEL_W] ? '1 : sum[LEVEL_W-1:0];
				end else begin
					s.brightness = (s.brightness > regs.step_size) ?
						s.brightness - regs.step_size : '0;
				end
			end
			// zero delay acts as one tick
			s.wait_count = (regs.step_delay == '0) ? '0 : regs.step_delay - 1'b1;
		end
		st_d = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (step_en) begin
			st_q <= st_d;
		end
	end

	assign res_next = '{
		level:      st_d.brightness,
		stopped:    st_d.halted,
		descending: st_d.going_down
	};

`ifndef SYNTH
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(st_q))
		else $error("ramp state moved without a tick");
	a_wait_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !restart && st_q.wait_count != '0 |=>
		st_q.wait_count == $past(st_q.wait_count) - 1'b1 &&
		st_q.brightness == $past(st_q.brightness))
		else $error("wait counter did not count down");
	// repeatable-only mode restarts at a boundary even after a stop
	a_halt_holds_level: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !restart && st_q.halted && !(regs.repeatable && !regs.reversible) |=>
		st_q.halted && st_q.brightness == $past(st_q.brightness))
		else $error("stopped ramp changed level");
`endif

endmodule
